FILE: hw/rtl/indentation_aware_tokenizer_core_assert.svh
`ifndef INDENTATION_AWARE_TOKENIZER_CORE_ASSERT_SVH
`define INDENTATION_AWARE_TOKENIZER_CORE_ASSERT_SVH

// Clocked assertion, quiet while reset is held.
`define IATC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication form: when ante holds, cons must hold.
`define IATC_IMPLIES(lbl, ante, cons, msg) \
  `IATC_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

FILE: hw/rtl/iat_pkg.sv
package iat_pkg;

  localparam int StackDepthDef = 16;
  localparam int OFFSET_W = 24;
  localparam int LEN_W    = 16;
  localparam int LINE_W   = 16;
  localparam int CHAR_W   = 8;
  localparam int PREFIX_W = 40;

  typedef enum logic [4:0] {
    TK_NAME, TK_INT, TK_NEWLINE, TK_INDENT, TK_DEDENT, TK_END,
    TK_IF, TK_ELSE, TK_WHILE, TK_PRINT, TK_TRUE, TK_FALSE, TK_NOT, TK_AND, TK_OR,
    TK_EQUALS, TK_PLUS, TK_MINUS, TK_STAR, TK_LPAREN, TK_RPAREN, TK_COLON,
    TK_LESS, TK_GREATER, TK_EQEQ, TK_BANGEQ, TK_LESSEQ, TK_GREATEREQ
  } token_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE, ERR_INDENT, ERR_CHAR, ERR_OVERFLOW
  } err_t;

  typedef enum logic [2:0] {
    PK_NONE, PK_INT, PK_NAME, PK_EQ, PK_LT, PK_GT, PK_BANG
  } pend_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_START, ST_LINE, ST_DED, ST_CHAR, ST_EFLUSH, ST_ENL, ST_EDED, ST_FINISH
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_PAIR, OP_EXTEND, OP_FLUSH, OP_SPACE, OP_LSNL, OP_OVF,
    OP_PUSH, OP_DEDENT, OP_INCONS, OP_LSEND, OP_CHAR, OP_EOS_NL, OP_EOS_DED,
    OP_EOS_END, OP_RESET, OP_FINISH
  } op_t;

  typedef struct packed {
    logic eos;
    logic halted;
    logic pk_op;
    logic pk_run;
    logic c_eq;
    logic more;
    logic at_ls;
    logic c_space;
    logic c_nl;
    logic sc_gt;
    logic top_full;
    logic top_zero;
    logic sc_lt;
    logic sc_ne;
    logic need_nl;
    logic slot_ok;
    logic fin_ok;
  } status_t;

  typedef struct packed {
    token_kind_t         kind;
    logic [OFFSET_W-1:0] start;
    logic [LEN_W-1:0]    len;
    logic [LINE_W-1:0]   line;
    err_t                err;
  } res_t;

  // keyword bytes, first character in the low byte
  function automatic token_kind_t name_kind(input logic [PREFIX_W-1:0] p,
                                            input logic [LEN_W-1:0] n);
    token_kind_t k;
    k = TK_NAME;
    if (n == 16'd2 && p == 40'h000000_6669) k = TK_IF;
    if (n == 16'd4 && p == 40'h00_65736c65) k = TK_ELSE;
    if (n == 16'd5 && p == 40'h656c696877) k = TK_WHILE;
    if (n == 16'd5 && p == 40'h746e697270) k = TK_PRINT;
    if (n == 16'd4 && p == 40'h00_65757254) k = TK_TRUE;
    if (n == 16'd5 && p == 40'h65736c6146) k = TK_FALSE;
    if (n == 16'd3 && p == 40'h0000_746f6e) k = TK_NOT;
    if (n == 16'd3 && p == 40'h0000_646e61) k = TK_AND;
    if (n == 16'd2 && p == 40'h000000_726f) k = TK_OR;
    return k;
  endfunction

endpackage

FILE: hw/rtl/indentation_aware_tokenizer_core.sv
// Streaming tokenizer for an indentation-sensitive language. Each request is one
// source byte (in_command 0) or end of source (in_command 1); each result is a
// token with kind, byte offset, length and line, or a single error result, and
// out_last_of_run marks the final result of a request. A request holds in_ready
// low from acceptance while the controller steps (at most one token per step)
// and the one-deep result slot ahead of the output register drains into it;
// a dedent run or end-of-source flush adds a step for each closed indent level.
// Output back-pressure stalls the sequencer. After an error bytes are dropped
// until end of source, which returns the block to its reset state.
module indentation_aware_tokenizer_core #(
  parameter int STACK_DEPTH = iat_pkg::StackDepthDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_command,
  input  logic [iat_pkg::CHAR_W-1:0]    in_char_code,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [4:0]                    out_token_kind,
  output logic [iat_pkg::OFFSET_W-1:0]  out_token_start,
  output logic [iat_pkg::LEN_W-1:0]     out_token_length,
  output logic [iat_pkg::LINE_W-1:0]    out_token_line,
  output logic [1:0]                    out_error_code,
  output logic                          out_last_of_run
);
  import iat_pkg::*;

  status_t st;
  op_t     op;

  iat_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .op       (op)
  );

  iat_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .op               (op),
    .st               (st),
    .in_command       (in_command),
    .in_char_code     (in_char_code),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_token_start  (out_token_start),
    .out_token_length (out_token_length),
    .out_token_line   (out_token_line),
    .out_error_code   (out_error_code),
    .out_last_of_run  (out_last_of_run)
  );

endmodule

FILE: hw/rtl/iat_ctrl.sv
module iat_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  iat_pkg::status_t st,
  output iat_pkg::op_t     op
);
  import iat_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_START;
      ST_START: begin
        if (st.slot_ok) begin
          if (st.eos) state_nxt = st.halted ? ST_FINISH : ST_EFLUSH;
          else if (st.halted) state_nxt = ST_FINISH;
          else if (st.pk_op && st.c_eq) state_nxt = ST_FINISH;
          else if (st.pk_run && st.more) state_nxt = ST_FINISH;
          else state_nxt = ST_LINE;
        end
      end
      ST_LINE: begin
        if (st.slot_ok) begin
          if (st.halted || !st.at_ls) state_nxt = ST_FINISH;
          else if (st.c_space || st.c_nl) state_nxt = ST_FINISH;
          else if (st.sc_gt) state_nxt = st.top_full ? ST_FINISH : ST_CHAR;
          else state_nxt = ST_DED;
        end
      end
      ST_DED: begin
        if (st.slot_ok && !(!st.top_zero && st.sc_lt))
          state_nxt = st.sc_ne ? ST_FINISH : ST_CHAR;
      end
      ST_CHAR:   if (st.slot_ok) state_nxt = ST_FINISH;
      ST_EFLUSH: if (st.slot_ok) state_nxt = ST_ENL;
      ST_ENL:    if (st.slot_ok) state_nxt = st.halted ? ST_FINISH : ST_EDED;
      ST_EDED:   if (st.slot_ok && st.top_zero) state_nxt = ST_FINISH;
      ST_FINISH: if (st.fin_ok) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    op = OP_NONE;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) op = OP_LATCH;
      end
      ST_START: begin
        if (st.slot_ok) begin
          if (st.eos) begin
            if (st.halted) op = OP_RESET;
          end else if (!st.halted) begin
            if (st.pk_op) op = st.c_eq ? OP_PAIR : OP_FLUSH;
            else if (st.pk_run) op = st.more ? OP_EXTEND : OP_FLUSH;
          end
        end
      end
      ST_LINE: begin
        if (st.slot_ok && !st.halted) begin
          if (!st.at_ls) op = OP_CHAR;
          else if (st.c_space) op = OP_SPACE;
          else if (st.c_nl) op = OP_LSNL;
          else if (st.sc_gt) op = st.top_full ? OP_OVF : OP_PUSH;
        end
      end
      ST_DED: begin
        if (st.slot_ok) begin
          if (!st.top_zero && st.sc_lt) op = OP_DEDENT;
          else op = st.sc_ne ? OP_INCONS : OP_LSEND;
        end
      end
      ST_CHAR:   if (st.slot_ok) op = OP_CHAR;
      ST_EFLUSH: if (st.slot_ok) op = OP_FLUSH;
      ST_ENL: begin
        if (st.slot_ok) begin
          if (st.halted) op = OP_RESET;
          else if (st.need_nl) op = OP_EOS_NL;
        end
      end
      ST_EDED:   if (st.slot_ok) op = st.top_zero ? OP_EOS_END : OP_EOS_DED;
      ST_FINISH: if (st.fin_ok) op = OP_FINISH;
      default:   op = OP_NONE;
    endcase
  end

endmodule

FILE: hw/rtl/iat_dp.sv
module iat_dp #(
  parameter int STACK_DEPTH = iat_pkg::StackDepthDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  iat_pkg::op_t                  op,
  output iat_pkg::status_t              st,
  input  logic                          in_command,
  input  logic [iat_pkg::CHAR_W-1:0]    in_char_code,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [4:0]                    out_token_kind,
  output logic [iat_pkg::OFFSET_W-1:0]  out_token_start,
  output logic [iat_pkg::LEN_W-1:0]     out_token_length,
  output logic [iat_pkg::LINE_W-1:0]    out_token_line,
  output logic [1:0]                    out_error_code,
  output logic                          out_last_of_run
);
  import iat_pkg::*;

  localparam int TW = $clog2(STACK_DEPTH);
  localparam logic [TW-1:0] TopMax = TW'(STACK_DEPTH - 1);

  logic                cmd_r, cmd_nxt;
  logic [CHAR_W-1:0]   c_r, c_nxt;
  logic [LEN_W-1:0]    lvl_r [STACK_DEPTH];
  logic [TW-1:0]       top_r, top_nxt;
  logic                at_ls_r, at_ls_nxt;
  logic [LEN_W-1:0]    sc_r, sc_nxt;
  pend_t               pk_r, pk_nxt;
  logic [OFFSET_W-1:0] ps_r, ps_nxt;
  logic [LEN_W-1:0]    pl_r, pl_nxt;
  logic [LINE_W-1:0]   pline_r, pline_nxt;
  logic [PREFIX_W-1:0] np_r, np_nxt;
  logic [LINE_W-1:0]   line_r, line_nxt;
  logic [OFFSET_W-1:0] off_r, off_nxt;
  logic                any_r, any_nxt;
  logic                lastnl_r, lastnl_nxt;
  logic                halted_r, halted_nxt;
  logic                hold_v_r, hold_v_nxt;
  res_t                hold_r, hold_nxt;
  logic                out_v_r, out_v_nxt;
  res_t                out_r, out_nxt;
  logic                last_r, last_nxt;

  logic          emit, adv, do_reset, lvl_we;
  res_t          e;
  logic [LEN_W-1:0] lvl_top;
  logic          is_digit, is_alpha, out_free;

  assign lvl_top  = (top_r == '0) ? '0 : lvl_r[top_r];
  assign is_digit = c_r inside {[8'h30:8'h39]};
  assign is_alpha = (c_r inside {[8'h61:8'h7a], [8'h41:8'h5a]}) || c_r == 8'h5f;
  assign out_free = !out_v_r || out_ready;

  always_comb begin
    st          = '0;
    st.eos      = cmd_r;
    st.halted   = halted_r;
    st.pk_op    = pk_r inside {PK_EQ, PK_LT, PK_GT, PK_BANG};
    st.pk_run   = pk_r inside {PK_INT, PK_NAME};
    st.c_eq     = c_r == 8'h3d;
    st.more     = (pk_r == PK_INT) ? is_digit : (is_alpha || is_digit);
    st.at_ls    = at_ls_r;
    st.c_space  = c_r == 8'h20;
    st.c_nl     = c_r == 8'h0a;
    st.sc_gt    = sc_r > lvl_top;
    st.top_full = top_r == TopMax;
    st.top_zero = top_r == '0;
    st.sc_lt    = sc_r < lvl_top;
    st.sc_ne    = sc_r != lvl_top;
    st.need_nl  = any_r && !lastnl_r;
    st.slot_ok  = !hold_v_r || out_free;
    st.fin_ok   = !hold_v_r || out_free;
  end

  always_comb begin
    cmd_nxt = cmd_r;  c_nxt = c_r;  top_nxt = top_r;  at_ls_nxt = at_ls_r;
    sc_nxt = sc_r;  pk_nxt = pk_r;  ps_nxt = ps_r;  pl_nxt = pl_r;
    pline_nxt = pline_r;  np_nxt = np_r;  line_nxt = line_r;  off_nxt = off_r;
    any_nxt = any_r;  lastnl_nxt = lastnl_r;  halted_nxt = halted_r;
    emit = 1'b0;  adv = 1'b0;  do_reset = 1'b0;  lvl_we = 1'b0;
    e = '{kind: TK_NAME, start: off_r, len: '0, line: line_r, err: ERR_NONE};
    case (op)
      OP_LATCH: begin
        cmd_nxt = in_command;
        c_nxt   = in_char_code;
      end
      OP_PAIR: begin
        emit = 1'b1;
        e.start = ps_r;  e.line = pline_r;  e.len = 16'd2;
        case (pk_r)
          PK_EQ:   e.kind = TK_EQEQ;
          PK_LT:   e.kind = TK_LESSEQ;
          PK_GT:   e.kind = TK_GREATEREQ;
          default: e.kind = TK_BANGEQ;
        endcase
        pk_nxt = PK_NONE;
        adv = 1'b1;
      end
      OP_EXTEND: begin
        if (pk_r == PK_NAME && pl_r < 16'd5)
          np_nxt = np_r | (PREFIX_W'(c_r) << {pl_r[2:0], 3'b000});
        if (pl_r != '1) pl_nxt = pl_r + 1'b1;
        adv = 1'b1;
      end
      OP_FLUSH: begin
        pk_nxt = PK_NONE;
        e.start = ps_r;  e.line = pline_r;  e.len = 16'd1;
        case (pk_r)
          PK_INT:  begin emit = 1'b1; e.kind = TK_INT; e.len = pl_r; end
          PK_NAME: begin emit = 1'b1; e.kind = name_kind(np_r, pl_r); e.len = pl_r; end
          PK_EQ:   begin emit = 1'b1; e.kind = TK_EQUALS; end
          PK_LT:   begin emit = 1'b1; e.kind = TK_LESS; end
          PK_GT:   begin emit = 1'b1; e.kind = TK_GREATER; end
          PK_BANG: begin emit = 1'b1; e.err = ERR_CHAR; e.len = '0; end
          default: emit = 1'b0;
        endcase
      end
      OP_SPACE: begin
        if (sc_r != '1) sc_nxt = sc_r + 1'b1;
        adv = 1'b1;
      end
      OP_LSNL: begin
        emit = 1'b1;  e.kind = TK_NEWLINE;
        if (line_r != '1) line_nxt = line_r + 1'b1;
        sc_nxt = '0;
        adv = 1'b1;
      end
      OP_OVF: begin
        emit = 1'b1;  e.err = ERR_OVERFLOW;
      end
      OP_PUSH: begin
        emit = 1'b1;  e.kind = TK_INDENT;
        top_nxt = top_r + 1'b1;
        lvl_we = 1'b1;
        at_ls_nxt = 1'b0;
        sc_nxt = '0;
      end
      OP_DEDENT, OP_EOS_DED: begin
        emit = 1'b1;  e.kind = TK_DEDENT;
        top_nxt = top_r - 1'b1;
      end
      OP_INCONS: begin
        emit = 1'b1;  e.err = ERR_INDENT;
      end
      OP_LSEND: begin
        at_ls_nxt = 1'b0;
        sc_nxt = '0;
      end
      OP_CHAR: begin
        adv = 1'b1;
        e.len = 16'd1;
        if (c_r == 8'h20 || c_r == 8'h09) begin
          adv = 1'b1;
        end else if (c_r == 8'h0a) begin
          emit = 1'b1;  e.kind = TK_NEWLINE;  e.len = '0;
          if (line_r != '1) line_nxt = line_r + 1'b1;
          at_ls_nxt = 1'b1;
        end else if (is_digit || is_alpha || c_r inside {8'h3d, 8'h3c, 8'h3e, 8'h21}) begin
          ps_nxt = off_r;  pl_nxt = 16'd1;  pline_nxt = line_r;
          if (is_digit) pk_nxt = PK_INT;
          else if (is_alpha) begin
            pk_nxt = PK_NAME;
            np_nxt = PREFIX_W'(c_r);
          end else if (c_r == 8'h3d) pk_nxt = PK_EQ;
          else if (c_r == 8'h3c) pk_nxt = PK_LT;
          else if (c_r == 8'h3e) pk_nxt = PK_GT;
          else pk_nxt = PK_BANG;
        end else begin
          emit = 1'b1;
          case (c_r)
            8'h2b:   e.kind = TK_PLUS;
            8'h2d:   e.kind = TK_MINUS;
            8'h2a:   e.kind = TK_STAR;
            8'h28:   e.kind = TK_LPAREN;
            8'h29:   e.kind = TK_RPAREN;
            8'h3a:   e.kind = TK_COLON;
            default: begin
              e.err = ERR_CHAR;  e.len = '0;  adv = 1'b0;
            end
          endcase
        end
      end
      OP_EOS_NL: begin
        emit = 1'b1;  e.kind = TK_NEWLINE;
      end
      OP_EOS_END: begin
        emit = 1'b1;  e.kind = TK_END;
        do_reset = 1'b1;
      end
      OP_RESET: do_reset = 1'b1;
      default: emit = 1'b0;
    endcase

    if (emit) begin
      if (e.err == ERR_NONE) begin
        any_nxt = 1'b1;
        lastnl_nxt = e.kind == TK_NEWLINE;
      end else begin
        halted_nxt = 1'b1;
      end
    end
    if (adv && off_r != '1) off_nxt = off_r + 1'b1;

    if (do_reset) begin
      top_nxt = '0;  at_ls_nxt = 1'b1;  sc_nxt = '0;  pk_nxt = PK_NONE;
      ps_nxt = '0;  pl_nxt = '0;  pline_nxt = LINE_W'(1);  np_nxt = '0;
      line_nxt = LINE_W'(1);  off_nxt = '0;  any_nxt = 1'b0;
      lastnl_nxt = 1'b0;  halted_nxt = 1'b0;
    end
  end

  // one-result holding slot so the final result of a request can be flagged
  always_comb begin
    hold_v_nxt = hold_v_r;
    hold_nxt   = hold_r;
    out_v_nxt  = out_v_r && !out_ready;
    out_nxt    = out_r;
    last_nxt   = last_r;
    if (emit) begin
      if (hold_v_r) begin
        out_v_nxt = 1'b1;
        out_nxt   = hold_r;
        last_nxt  = 1'b0;
      end
      hold_nxt   = e;
      hold_v_nxt = 1'b1;
    end else if (op == OP_FINISH && hold_v_r) begin
      out_v_nxt  = 1'b1;
      out_nxt    = hold_r;
      last_nxt   = 1'b1;
      hold_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= '0;  at_ls_r <= 1'b1;  sc_r <= '0;  pk_r <= PK_NONE;
      ps_r <= '0;  pl_r <= '0;  pline_r <= LINE_W'(1);  np_r <= '0;
      line_r <= LINE_W'(1);  off_r <= '0;  any_r <= 1'b0;  lastnl_r <= 1'b0;
      halted_r <= 1'b0;  hold_v_r <= 1'b0;  out_v_r <= 1'b0;  cmd_r <= 1'b0;
    end else begin
      top_r <= top_nxt;  at_ls_r <= at_ls_nxt;  sc_r <= sc_nxt;  pk_r <= pk_nxt;
      ps_r <= ps_nxt;  pl_r <= pl_nxt;  pline_r <= pline_nxt;  np_r <= np_nxt;
      line_r <= line_nxt;  off_r <= off_nxt;  any_r <= any_nxt;
      lastnl_r <= lastnl_nxt;  halted_r <= halted_nxt;  hold_v_r <= hold_v_nxt;
      out_v_r <= out_v_nxt;  cmd_r <= cmd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r    <= c_nxt;
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
    last_r <= last_nxt;
    if (lvl_we) lvl_r[top_nxt] <= sc_r;
  end

  assign out_valid        = out_v_r;
  assign out_token_kind   = out_r.kind;
  assign out_token_start  = out_r.start;
  assign out_token_length = out_r.len;
  assign out_token_line   = out_r.line;
  assign out_error_code   = out_r.err;
  assign out_last_of_run  = last_r;

endmodule

FILE: hw/rtl/iat_checker.sv
`include "indentation_aware_tokenizer_core_assert.svh"

module iat_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [4:0] out_token_kind,
  input logic [1:0] out_error_code,
  input logic       out_last_of_run
);
  import iat_pkg::*;

  `IATC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `IATC_ASSERT(a_one_req, in_valid && in_ready |=> !in_ready, "second request taken mid-run")
  `IATC_IMPLIES(a_err_last, out_valid && out_error_code != ERR_NONE, out_last_of_run, "error not last")
  `IATC_IMPLIES(a_end_last, out_valid && out_token_kind == TK_END && out_error_code == ERR_NONE, out_last_of_run, "END not last")

endmodule

bind indentation_aware_tokenizer_core iat_checker u_iat_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_token_kind  (out_token_kind),
  .out_error_code  (out_error_code),
  .out_last_of_run (out_last_of_run)
);
